FILE: rtl/core/led_color_stack_pwm_macros.svh
// Assertion helpers used by the checker file.
`ifndef LED_COLOR_STACK_PWM_MACROS_SVH
`define LED_COLOR_STACK_PWM_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define LCSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define LCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/lcsp_pkg.sv
package lcsp_pkg;

  localparam int unsigned ColorW = 24;
  localparam logic [7:0] RedScaleReset = 8'd100;
  localparam logic [7:0] DutyMax = 8'd255;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REPLACE = 2'd2
  } opcode_e;

  // What a stack cell loads on the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_UP,
    CELL_TAKE_DN
  } cell_op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] color;
  } lcsp_in_t;

  typedef struct packed {
    logic [7:0] red_duty;
    logic [7:0] green_duty;
    logic [7:0] blue_duty;
    logic       invalid_color;
    logic       overflow;
    logic [4:0] depth;
  } lcsp_out_t;

  // Per-beat status that rides along with the color math.
  typedef struct packed {
    logic       invalid_color;
    logic       overflow;
    logic [4:0] depth;
  } lcsp_meta_t;

endpackage

FILE: rtl/core/lcsp_cell.sv
module lcsp_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lcsp_pkg::cell_op_e       op_i,
  input  logic [23:0]              up_i,
  input  logic [23:0]              dn_i,
  output logic [23:0]              color_o
);
  import lcsp_pkg::*;

  logic [ColorW-1:0] color_d, color_q;

  always_comb begin
    case (op_i)
      CELL_HOLD:    color_d = color_q;
      CELL_TAKE_UP: color_d = up_i;
      CELL_TAKE_DN: color_d = dn_i;
      default:      color_d = color_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= '0;
    end else begin
      color_q <= color_d;
    end
  end

  assign color_o = color_q;

endmodule

FILE: rtl/core/lcsp_duty.sv
module lcsp_duty (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  logic                 a_vld_i,
  input  lcsp_pkg::lcsp_meta_t a_meta_i,
  input  logic [23:0]          top_color_i,
  input  logic [7:0]           red_scale_i,
  output logic                 out_vld_o,
  output lcsp_pkg::lcsp_out_t  out_data_o
);
  import lcsp_pkg::*;

  logic        b_vld_q;
  logic [15:0] b_prod_q, prod_d;
  logic [7:0]  b_g_q, b_b_q;
  lcsp_meta_t  b_meta_q;

  logic [15:0] div_sum;
  logic [7:0]  red_q8;

  logic      out_vld_q;
  lcsp_out_t out_data_q, out_data_d;

  assign prod_d = {8'd0, top_color_i[23:16]} * {8'd0, red_scale_i};

  // floor(p / 255) for p up to 255 * 255: (p + (p >> 8) + 1) >> 8
  assign div_sum = b_prod_q + {8'd0, b_prod_q[15:8]} + 16'd1;
  assign red_q8  = div_sum[15:8];

  always_comb begin
    out_data_d.red_duty      = DutyMax - red_q8;
    out_data_d.green_duty    = DutyMax - b_g_q;
    out_data_d.blue_duty     = DutyMax - b_b_q;
    out_data_d.invalid_color = b_meta_q.invalid_color;
    out_data_d.overflow      = b_meta_q.overflow;
    out_data_d.depth         = b_meta_q.depth;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv_i) begin
      b_vld_q   <= a_vld_i;
      out_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_prod_q   <= prod_d;
      b_g_q      <= top_color_i[15:8];
      b_b_q      <= top_color_i[7:0];
      b_meta_q   <= a_meta_i;
      out_data_q <= out_data_d;
    end
  end

  assign out_vld_o  = out_vld_q;
  assign out_data_o = out_data_q;

endmodule

FILE: rtl/core/led_color_stack_pwm.sv
// Path: an accepted beat runs through stage A, stage B and the output register.
// Throughput: one beat per cycle while not stalled; in_stall_o is high exactly while a held
//   output beat is stalled, so the whole three-register pipe freezes together.
// Reset: the stack holds one black entry, red_scale is 100, the pipe is empty.
//   No clearing pass; the block takes beats right after reset.
module led_color_stack_pwm #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcsp_pkg::lcsp_in_t  in_data_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcsp_pkg::lcsp_out_t out_data_o,
  // red_scale register
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import lcsp_pkg::*;

  localparam int unsigned TopW = $clog2(STACK_DEPTH);

  // The stack is a row of cells; cell 0 is always the top entry. A push shifts
  // every cell down by one, a pop shifts every cell up by one, and a replace
  // that keeps the depth just reloads cell 0. Cells past the current depth
  // hold stale data that is never shown.
  logic [ColorW-1:0] cell_color [STACK_DEPTH];
  cell_op_e          cell_op    [STACK_DEPTH];

  logic [TopW-1:0] top_d, top_q;
  logic [7:0]      red_scale_q;

  logic       accept, adv;
  logic       bad, full;
  logic [4:0]  depth_w;
  lcsp_meta_t  a_meta_d, a_meta_q;
  logic        a_vld_q;
  logic        out_vld;

  // Pipe moves whenever the output register is free or being drained.
  assign adv        = !(out_vld && out_stall_i);
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;

  // Stack control: one decision per beat, fanned out to every cell.
  always_comb begin
    top_d = top_q;
    bad   = 1'b0;
    full  = 1'b0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    if (accept) begin
      case (in_data_i.opcode)
        OP_PUSH: begin
          bad = |in_data_i.color[31:24];
          if (top_q == TopW'(STACK_DEPTH - 1)) begin
            full = 1'b1;                      // refused, stack untouched
          end else begin
            top_d = top_q + TopW'(1);
            for (int i = 0; i < STACK_DEPTH; i++) begin
              cell_op[i] = CELL_TAKE_UP;
            end
          end
        end
        OP_POP: begin
          if (top_q != '0) begin              // last entry is never removed
            top_d = top_q - TopW'(1);
            for (int i = 0; i < STACK_DEPTH; i++) begin
              cell_op[i] = CELL_TAKE_DN;
            end
          end
        end
        OP_REPLACE: begin
          bad = |in_data_i.color[31:24];
          if (top_q != '0) begin
            // pop then push: depth unchanged, only the top is rewritten
            cell_op[0] = CELL_TAKE_UP;
          end else if (top_q == TopW'(STACK_DEPTH - 1)) begin
            full = 1'b1;
          end else begin
            // one-entry stack: the pop is a no-op, so the push grows it
            top_d = top_q + TopW'(1);
            for (int i = 0; i < STACK_DEPTH; i++) begin
              cell_op[i] = CELL_TAKE_UP;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // depth reported modulo 32
  assign depth_w = 5'(top_d) + 5'd1;

  always_comb begin
    a_meta_d.invalid_color = bad;
    a_meta_d.overflow      = full;
    a_meta_d.depth         = depth_w;
  end

  // Cell row: cell 0 loads the incoming color, the last cell reloads itself
  // on a pop.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [ColorW-1:0] up_s, dn_s;
    if (i == 0) begin : g_head
      assign up_s = in_data_i.color[ColorW-1:0];
    end else begin : g_body
      assign up_s = cell_color[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign dn_s = cell_color[i];
    end else begin : g_mid
      assign dn_s = cell_color[i+1];
    end
    lcsp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op[i]),
      .up_i    (up_s),
      .dn_i    (dn_s),
      .color_o (cell_color[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      red_scale_q <= RedScaleReset;
      a_vld_q     <= 1'b0;
    end else begin
      if (accept) begin
        top_q <= top_d;
      end
      if (cfg_we_i) begin
        red_scale_q <= cfg_wdata_i;
      end
      if (adv) begin
        a_vld_q <= accept;
      end
    end
  end

  // Flags of the beat whose stack update is now visible in cell 0.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_meta_q <= a_meta_d;
    end
  end

  // Stage B multiplies red by the scale, the output stage divides by 255
  // and inverts all three duties.
  lcsp_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .a_vld_i     (a_vld_q),
    .a_meta_i    (a_meta_q),
    .top_color_i (cell_color[0]),
    .red_scale_i (red_scale_q),
    .out_vld_o   (out_vld),
    .out_data_o  (out_data_o)
  );

  assign out_valid_o = out_vld;

endmodule

FILE: rtl/core/lcsp_checker.sv
`include "led_color_stack_pwm_macros.svh"

module lcsp_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input lcsp_pkg::lcsp_out_t out_data_o
);

  // A stalled output beat stays put.
  `LCSP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled output beat changed")

  // The pipe freezes as a whole: a held output beat blocks the input side.
  `LCSP_ASSERT_NOW(a_stall_chain, out_valid_o && out_stall_i, in_stall_o,
                   "input accepted while output held")

  // A refused push only happens on a full stack.
  `LCSP_ASSERT_NOW(a_ovf_depth, out_valid_o && out_data_o.overflow,
                   out_data_o.depth == 5'(STACK_DEPTH), "overflow reported below full depth")

endmodule

bind led_color_stack_pwm lcsp_checker #(.STACK_DEPTH(STACK_DEPTH)) u_lcsp_checker (.*);
